// ===== hw/rtl/gcnwgu_pkg.sv =====
// Package for the GCN weight-gradient update block: operation codes, data
// widths, default table dimensions and the request/result structs of the
// update stage. Depends on nothing.
package gcnwgu_pkg;

    // Default table dimensions.
    localparam int DEF_FEATURES = 16;
    localparam int DEF_OUTPUTS  = 16;

    // Width used to compare 4-bit indexes with dimensions up to 256.
    localparam int DIM_W = 9;

    // Value widths.
    localparam int W_W    = 32;   // weight, Q16.16
    localparam int G_W    = 48;   // gradient, Q32.16
    localparam int LR_W   = 16;   // learning rate, Q0.16
    localparam int PROD_W = 64;   // product ahead of rounding, Q32.32

    localparam logic [LR_W-1:0] LR_RESET = 16'd655;

    // Saturation limits.
    localparam logic [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
    localparam logic [G_W-1:0] G_MAX = {1'b0, {(G_W-1){1'b1}}};
    localparam logic [G_W-1:0] G_MIN = {1'b1, {(G_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_ACCUM  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } op_e_t;

    // Operands of one operation as they enter the update stage.
    typedef struct packed {
        op_e_t             op;
        logic              in_range;
        logic [W_W-1:0]    ax;
        logic [W_W-1:0]    w_old;
        logic [G_W-1:0]    g_old;
        logic [PROD_W-1:0] prod;
    } upd_req_t;

    // Table entry to write back and the result to deliver.
    typedef struct packed {
        logic           wr_en;
        logic [W_W-1:0] w_new;
        logic [G_W-1:0] g_new;
        logic [W_W-1:0] weight_out;
        logic           saturated;
    } upd_res_t;

endpackage

// ===== hw/rtl/gcn_weight_gradient_update.sv =====
// Top level of the GCN weight-gradient update block: stream ports, learning
// rate register, pipeline control, forwarding and the multiply stage.
// Depends on gcnwgu_pkg, gcnwgu_tables and gcnwgu_arith.
//
//  Port group   Dir  Width  Contents
//  s_axis_*     in   112    one operation request: op, indexes, ax, z, grad_h
//  m_axis_*     out  32+1   weight of the addressed entry, saturation flag
//  cfg_*        in   16     learning rate, Q0.16
//
// A request passes three register stages: stage 1 (table read data arrives,
// multiply), stage 2 (update and write-back) and the output register. One
// request is taken per cycle while the pipeline does not stall. A request whose
// entry is still being updated by the request just ahead of it waits in stage 1
// until that write-back, so back-to-back requests to the same entry do not run
// at the full rate. After reset the gradient table is cleared one entry per
// cycle, during which no request is taken.
// When the result consumer stalls, the output register holds and the
// pipeline fills up before s_axis_tready falls.
module gcn_weight_gradient_update #(
    parameter int FEATURES = gcnwgu_pkg::DEF_FEATURES,
    parameter int OUTPUTS  = gcnwgu_pkg::DEF_OUTPUTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] op, [5:2] feature_index, [9:6] output_index, [41:10] ax_value,
    // [73:42] z_value, [105:74] grad_h, [111:106] zero
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] weight_out
    output logic [31:0]  m_axis_tdata,
    // [0] saturated
    output logic         m_axis_tuser,
    input  logic         cfg_wen,
    input  logic [15:0]  cfg_wdata
);

    localparam int DEPTH  = FEATURES * OUTPUTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW_W   = 17;   // wide enough for 15 * 256 + 15
    localparam int W_W    = gcnwgu_pkg::W_W;
    localparam int G_W    = gcnwgu_pkg::G_W;
    localparam int DIM_W  = gcnwgu_pkg::DIM_W;

    // Learning rate register.
    logic [gcnwgu_pkg::LR_W-1:0] lr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= gcnwgu_pkg::LR_RESET;
        end
        else if (cfg_wen)
        begin
            lr_reg <= cfg_wdata;
        end
    end

    // Request fields.
    logic [3:0]      in_f;
    logic [3:0]      in_k;
    logic [AW_W-1:0] in_addr_wide;
    logic            in_range;
    logic            accept;

    assign in_f         = s_axis_tdata[5:2];
    assign in_k         = s_axis_tdata[9:6];
    assign in_addr_wide = AW_W'(in_f) * AW_W'(OUTPUTS) + AW_W'(in_k);
    assign in_range     = ({5'd0, in_f} < DIM_W'(FEATURES))
                          && ({5'd0, in_k} < DIM_W'(OUTPUTS));

    // Stage 1: request registered, table data arrives, multiply.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    gcnwgu_pkg::op_e_t     s1_op_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic                  s1_in_range_reg;
    logic [W_W-1:0]        s1_ax_reg;
    logic [W_W-1:0]        s1_z_reg;
    logic [W_W-1:0]        s1_gh_reg;

    // Stage 2: update and write-back.
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    logic [ADDR_W-1:0]     s2_addr_reg;
    gcnwgu_pkg::upd_req_t  s2_req_reg;
    gcnwgu_pkg::upd_res_t  s2_res;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [W_W-1:0]        out_weight_reg;
    logic                  out_sat_reg;

    // Last entry written back; covers the write that the stage 1 read missed.
    logic                  wb_valid_reg;
    logic [ADDR_W-1:0]     wb_addr_reg;
    logic [W_W-1:0]        wb_weight_reg;
    logic [G_W-1:0]        wb_grad_reg;

    logic                  clearing;
    logic                  s2_adv;
    logic                  s2_free;
    logic                  hazard;
    logic                  s1_adv;
    logic                  s1_free;
    logic                  wr_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [W_W-1:0]        rd_weight;
    logic [G_W-1:0]        rd_grad;

    // The result leaves when the output register is empty or being taken.
    // Stage 1 holds behind a stage 2 request to the same entry, since that
    // entry's new value exists only at the end of this cycle.
    assign s2_adv  = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s2_free = !s2_valid_reg || s2_adv;
    assign hazard  = s1_valid_reg && s2_valid_reg && (s1_addr_reg == s2_addr_reg);
    assign s1_adv  = s1_valid_reg && s2_free && !hazard;
    assign s1_free = !s1_valid_reg || s1_adv;

    assign s_axis_tready = s1_free && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A held request re-reads its entry so the data stays current.
    assign rd_addr = accept ? in_addr_wide[ADDR_W-1:0] : s1_addr_reg;
    assign wr_en   = s2_adv && s2_res.wr_en;

    gcnwgu_tables #(
        .DEPTH (DEPTH)
    ) u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_weight (rd_weight),
        .rd_grad   (rd_grad),
        .wr_en     (wr_en),
        .wr_addr   (s2_addr_reg),
        .wr_weight (s2_res.w_new),
        .wr_grad   (s2_res.g_new),
        .clearing  (clearing)
    );

    // Current entry for the stage 1 request.
    logic                 fwd_hit;
    logic [W_W-1:0]       w_cur;
    logic [G_W-1:0]       g_cur;
    logic [W_W-1:0]       g_gate;
    logic signed [63:0]   prod_accum;
    logic signed [64:0]   prod_update;
    logic [63:0]          prod_sel;

    assign fwd_hit = wb_valid_reg && (wb_addr_reg == s1_addr_reg);
    assign w_cur   = fwd_hit ? wb_weight_reg : rd_weight;
    assign g_cur   = fwd_hit ? wb_grad_reg : rd_grad;

    // ReLU derivative: the upstream gradient passes only for a positive z.
    assign g_gate      = (!s1_z_reg[W_W-1] && (|s1_z_reg)) ? s1_gh_reg : '0;
    assign prod_accum  = $signed(s1_ax_reg) * $signed(g_gate);
    assign prod_update = $signed({1'b0, lr_reg}) * $signed(g_cur);
    assign prod_sel    = (s1_op_reg == gcnwgu_pkg::OP_UPDATE) ? prod_update[63:0]
                                                              : prod_accum;

    gcnwgu_arith u_arith (
        .req (s2_req_reg),
        .res (s2_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= gcnwgu_pkg::op_e_t'(s_axis_tdata[1:0]);
            s1_addr_reg     <= in_addr_wide[ADDR_W-1:0];
            s1_in_range_reg <= in_range;
            s1_ax_reg       <= s_axis_tdata[41:10];
            s1_z_reg        <= s_axis_tdata[73:42];
            s1_gh_reg       <= s_axis_tdata[105:74];
        end
        if (s1_adv)
        begin
            s2_addr_reg         <= s1_addr_reg;
            s2_req_reg.op       <= s1_op_reg;
            s2_req_reg.in_range <= s1_in_range_reg;
            s2_req_reg.ax       <= s1_ax_reg;
            s2_req_reg.w_old    <= w_cur;
            s2_req_reg.g_old    <= g_cur;
            s2_req_reg.prod     <= prod_sel;
        end
        if (s2_adv)
        begin
            out_weight_reg <= s2_res.weight_out;
            out_sat_reg    <= s2_res.saturated;
        end
        if (wr_en)
        begin
            wb_addr_reg   <= s2_addr_reg;
            wb_weight_reg <= s2_res.w_new;
            wb_grad_reg   <= s2_res.g_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_weight_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ===== hw/rtl/gcnwgu_tables.sv =====
// Weight and gradient tables of the GCN weight-gradient update block, with
// registered reads and the gradient clearing sweep after reset.
// Depends on gcnwgu_pkg.
module gcnwgu_tables #(
    parameter int  DEPTH  = gcnwgu_pkg::DEF_FEATURES * gcnwgu_pkg::DEF_OUTPUTS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [gcnwgu_pkg::W_W-1:0] rd_weight,
    output logic [gcnwgu_pkg::G_W-1:0] rd_grad,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [gcnwgu_pkg::W_W-1:0] wr_weight,
    input  logic [gcnwgu_pkg::G_W-1:0] wr_grad,
    output logic                       clearing
);

    logic [gcnwgu_pkg::W_W-1:0] weight_mem [DEPTH];
    logic [gcnwgu_pkg::G_W-1:0] grad_mem   [DEPTH];

    logic [gcnwgu_pkg::W_W-1:0] rd_weight_reg;
    logic [gcnwgu_pkg::G_W-1:0] rd_grad_reg;

    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    logic                       grad_we;
    logic [ADDR_W-1:0]          grad_waddr;
    logic [gcnwgu_pkg::G_W-1:0] grad_wdata;

    // The sweep zeroes one gradient entry per cycle; no item is in flight
    // while it runs, so it owns the gradient write port.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    assign grad_we    = clearing_reg || wr_en;
    assign grad_waddr = clearing_reg ? clr_cnt_reg : wr_addr;
    assign grad_wdata = clearing_reg ? '0 : wr_grad;

    always_ff @(posedge clk)
    begin
        if (wr_en && !clearing_reg)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        rd_weight_reg <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
        begin
            grad_mem[grad_waddr] <= grad_wdata;
        end
        rd_grad_reg <= grad_mem[rd_addr];
    end

    assign rd_weight = rd_weight_reg;
    assign rd_grad   = rd_grad_reg;
    assign clearing  = clearing_reg;

endmodule

// ===== hw/rtl/gcnwgu_arith.sv =====
// Update stage of the GCN weight-gradient update block: writes a weight, rounds
// the product, accumulates or steps the entry, and saturates; a read changes nothing.
// Depends on gcnwgu_pkg.
module gcnwgu_arith (
    input  gcnwgu_pkg::upd_req_t req,
    output gcnwgu_pkg::upd_res_t res
);

    localparam int G_W = gcnwgu_pkg::G_W;
    localparam int W_W = gcnwgu_pkg::W_W;

    logic [G_W-1:0] p_hi;
    logic           p_round;
    logic [G_W:0]   acc_sum;
    logic           acc_ovf;
    logic [G_W-1:0] g_acc;
    logic [G_W:0]   upd_diff;
    logic           upd_ovf;
    logic [W_W-1:0] w_upd;

    // Rounding to Q32.16 adds half an LSB and floors, which equals the
    // arithmetic shift plus bit 15 as a carry into the following add.
    assign p_hi    = req.prod[gcnwgu_pkg::PROD_W-1:16];
    assign p_round = req.prod[15];

    assign acc_sum = {req.g_old[G_W-1], req.g_old} + {p_hi[G_W-1], p_hi}
                     + (G_W+1)'(p_round);
    assign acc_ovf = acc_sum[G_W] ^ acc_sum[G_W-1];
    assign g_acc   = acc_ovf ? (acc_sum[G_W] ? gcnwgu_pkg::G_MIN : gcnwgu_pkg::G_MAX)
                             : acc_sum[G_W-1:0];

    // w - round(p) = w + ~floor(p) + 1 - p[15]
    assign upd_diff = {{(G_W+1-W_W){req.w_old[W_W-1]}}, req.w_old}
                      + {~p_hi[G_W-1], ~p_hi} + (G_W+1)'(!p_round);
    assign upd_ovf  = !((&upd_diff[G_W:W_W-1]) || !(|upd_diff[G_W:W_W-1]));
    assign w_upd    = upd_ovf ? (upd_diff[G_W] ? gcnwgu_pkg::W_MIN : gcnwgu_pkg::W_MAX)
                              : upd_diff[W_W-1:0];

    always_comb
    begin
        res.wr_en      = 1'b0;
        res.w_new      = req.w_old;
        res.g_new      = req.g_old;
        res.weight_out = req.w_old;
        res.saturated  = 1'b0;
        case (req.op)
            gcnwgu_pkg::OP_WRITE:
            begin
                res.wr_en      = 1'b1;
                res.w_new      = req.ax;
                res.weight_out = req.ax;
            end
            gcnwgu_pkg::OP_ACCUM:
            begin
                res.wr_en     = 1'b1;
                res.g_new     = g_acc;
                res.saturated = acc_ovf;
            end
            gcnwgu_pkg::OP_UPDATE:
            begin
                res.wr_en      = 1'b1;
                res.w_new      = w_upd;
                res.g_new      = '0;
                res.weight_out = w_upd;
                res.saturated  = upd_ovf;
            end
            default:
            begin
                res.wr_en = 1'b0;
            end
        endcase
        // An index beyond the table leaves the state alone and answers zero.
        if (!req.in_range)
        begin
            res.wr_en      = 1'b0;
            res.weight_out = '0;
            res.saturated  = 1'b0;
        end
    end

endmodule
